// ===== hdl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Partitioned FIR convolver package
// Shared widths, constants and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int PARTITION_SIZE_DEF = 64;
	localparam int MAX_TAPS_DEF       = 1024;

	localparam int SAMPLE_W  = 24;
	localparam int TAP_IDX_W = 10;
	localparam int LEN_W     = 11;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int FRAC_W    = SAMPLE_W - 1;

	localparam logic signed [SAMPLE_W-1:0] Q_MAX = 24'sh7F_FFFF;
	localparam logic signed [SAMPLE_W-1:0] Q_MIN = 24'sh80_0000;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic capture;
		logic load_tap;
		logic hist_write;
		logic mac_issue;
		logic pass_out;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mode_sample;
		logic len_zero;
		logic out_free;
		logic pipe_busy;
	} sts_t;

endpackage

// ===== hdl/pfc_in_if.sv =====
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries tap loads and audio samples.
// ----------------------------------------------------------------------------
interface pfc_in_if
	import pfc_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [TAP_IDX_W-1:0]       tap_index;
	logic signed [SAMPLE_W-1:0] tap_value;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, mode, tap_index, tap_value, sample, input ready);
	modport sink (input valid, mode, tap_index, tap_value, sample, output ready);
endinterface

// ===== hdl/pfc_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries convolved output samples.
// ----------------------------------------------------------------------------
interface pfc_out_if
	import pfc_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       saturated;

	modport source (output valid, out_sample, saturated, input ready);
	modport sink (input valid, out_sample, saturated, output ready);
endinterface

// ===== hdl/partitioned_fir_convolver.sv =====
// ----------------------------------------------------------------------------
// Partitioned FIR convolver
// Time-domain equivalent of uniformly partitioned overlap-add convolution
// with a loadable impulse response and a fixed output latency.
// ----------------------------------------------------------------------------
//  channel  | direction | transfers
//  ---------+-----------+-----------------------------------------------
//  item     | in        | tap load (mode 0) or audio sample (mode 1)
//  result   | out       | one output sample per audio sample
//  cfg      | in        | ir_length register write, no read-back
//
// A sample runs N taps through the multiply-accumulate loop, where N is the smaller
// of ir_length and the number of samples since the last load, this one included,
// both capped at MAX_TAPS; the single multiply-accumulate unit handles one tap
// per cycle through one read port of the tap memory and one of the history memory.
// The reset is asynchronous and clears all control state; no clearing pass.
// A result waiting on the result channel stalls the block only when the next
// result is ready to be written.
module partitioned_fir_convolver
	import pfc_pkg::*;
#(
	parameter int PARTITION_SIZE = PARTITION_SIZE_DEF,
	parameter int MAX_TAPS       = MAX_TAPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	pfc_in_if.sink           item,
	pfc_out_if.source        result
);
	cmd_t                          cmd;
	sts_t                          sts;
	logic [$clog2(MAX_TAPS+1)-1:0] n_taps;

	pfc_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.n_taps   (n_taps),
		.cmd      (cmd)
	);

	pfc_dp #(.PARTITION_SIZE(PARTITION_SIZE), .MAX_TAPS(MAX_TAPS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_mode       (item.mode),
		.in_tap_index  (item.tap_index),
		.in_tap_value  (item.tap_value),
		.in_sample     (item.sample),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.out_sample    (result.out_sample),
		.out_saturated (result.saturated),
		.cmd           (cmd),
		.sts           (sts),
		.n_taps        (n_taps)
	);
endmodule

// ===== hdl/pfc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/pfc_dp.sv =====
// ----------------------------------------------------------------------------
// Convolver datapath
// Tap, history and latency memories, the multiply-accumulate pipeline,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module pfc_dp
	import pfc_pkg::*;
#(
	parameter int PARTITION_SIZE = PARTITION_SIZE_DEF,
	parameter int MAX_TAPS       = MAX_TAPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [LEN_W-1:0]               cfg_data,
	input  logic                           in_mode,
	input  logic [TAP_IDX_W-1:0]           in_tap_index,
	input  logic signed [SAMPLE_W-1:0]     in_tap_value,
	input  logic signed [SAMPLE_W-1:0]     in_sample,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic signed [SAMPLE_W-1:0]     out_sample,
	output logic                           out_saturated,
	input  cmd_t                           cmd,
	output sts_t                           sts,
	output logic [$clog2(MAX_TAPS+1)-1:0]  n_taps
);
	localparam int TAW   = $clog2(MAX_TAPS);
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int LAW   = $clog2(PARTITION_SIZE);
	localparam int LCW   = $clog2(PARTITION_SIZE + 1);
	localparam int ACC_W = PROD_W + TAW;

	logic [LEN_W-1:0]           ir_len_q;
	logic                       mode_q;
	logic [TAP_IDX_W-1:0]       idx_q;
	logic signed [SAMPLE_W-1:0] tapv_q;
	logic signed [SAMPLE_W-1:0] smp_q;

	logic [TAW-1:0] hp_q;
	logic [CW-1:0]  hfill_q;
	logic [LAW-1:0] lp_q;
	logic [LCW-1:0] lfill_q;
	logic [TAW-1:0] hra_q;
	logic [TAW-1:0] tra_q;
	logic           lat_ok_q;

	logic                     v_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_sat_q;

	logic [SAMPLE_W-1:0]   tap_rd;
	logic [SAMPLE_W-1:0]   hist_rd;
	logic [SAMPLE_W:0]     lat_rd;
	logic                  idx_ok;
	logic [CW-1:0]         len_c;
	logic [CW-1:0]         avail;
	logic [TAW-1:0]        hp_next;
	logic [LAW-1:0]        lp_next;
	logic [ACC_W-1:0]      rnd;
	logic [ACC_W-47:0]     rnd_hi;
	logic signed [SAMPLE_W-1:0] y;
	logic                  y_sat;

	assign idx_ok  = 32'(idx_q) < 32'(MAX_TAPS);
	assign len_c   = (32'(ir_len_q) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(ir_len_q);
	assign avail   = (hfill_q == CW'(MAX_TAPS)) ? CW'(MAX_TAPS) : hfill_q + 1'b1;
	assign n_taps  = (len_c < avail) ? len_c : avail;
	assign hp_next = (hp_q == TAW'(MAX_TAPS - 1)) ? '0 : hp_q + 1'b1;
	assign lp_next = (lp_q == LAW'(PARTITION_SIZE - 1)) ? '0 : lp_q + 1'b1;

	assign sts.mode_sample = (mode_q == MODE_SAMPLE);
	assign sts.len_zero    = (ir_len_q == '0);
	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.pipe_busy   = v_s1 || v_s2;

	assign rnd    = acc_q + (ACC_W'(1) << (FRAC_W - 1));
	assign rnd_hi = rnd[ACC_W-1:2*FRAC_W];
	assign y_sat  = !((&rnd_hi) || !(|rnd_hi));
	assign y      = y_sat ? (rnd[ACC_W-1] ? Q_MIN : Q_MAX) : rnd[2*FRAC_W:FRAC_W];

	pfc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_tap_ram (
		.clk   (clk),
		.we    (cmd.load_tap && idx_ok),
		.waddr (TAW'(idx_q)),
		.wdata (tapv_q),
		.re    (cmd.mac_issue),
		.raddr (tra_q),
		.rdata (tap_rd)
	);

	pfc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
		.clk   (clk),
		.we    (cmd.hist_write),
		.waddr (hp_q),
		.wdata (smp_q),
		.re    (cmd.mac_issue),
		.raddr (hra_q),
		.rdata (hist_rd)
	);

	pfc_ram #(.WIDTH(SAMPLE_W + 1), .DEPTH(PARTITION_SIZE)) u_lat_ram (
		.clk   (clk),
		.we    (cmd.finish),
		.waddr (lp_q),
		.wdata ({y_sat, y}),
		.re    (cmd.hist_write),
		.raddr (lp_next),
		.rdata (lat_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_len_q    <= '0;
			hp_q        <= '0;
			hfill_q     <= '0;
			lp_q        <= '0;
			lfill_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ir_len_q <= cfg_data;
			end
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
			if (cmd.load_tap) begin
				hp_q    <= '0;
				hfill_q <= '0;
				lp_q    <= '0;
				lfill_q <= '0;
			end
			if (cmd.hist_write) begin
				hp_q <= hp_next;
				if (hfill_q != CW'(MAX_TAPS)) begin
					hfill_q <= hfill_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				lp_q <= lp_next;
				if (lfill_q != LCW'(PARTITION_SIZE)) begin
					lfill_q <= lfill_q + 1'b1;
				end
			end
			if (cmd.finish || cmd.pass_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			idx_q  <= in_tap_index;
			tapv_q <= in_tap_value;
			smp_q  <= in_sample;
		end
		if (cmd.hist_write) begin
			hra_q    <= hp_q;
			tra_q    <= '0;
			acc_q    <= '0;
			lat_ok_q <= LCW'(lp_next) < lfill_q;
		end
		if (cmd.mac_issue) begin
			tra_q <= tra_q + 1'b1;
			hra_q <= (hra_q == '0) ? TAW'(MAX_TAPS - 1) : hra_q - 1'b1;
		end
		prod_s2 <= $signed(tap_rd) * $signed(hist_rd);
		if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.pass_out) begin
			out_sample_q <= smp_q;
			out_sat_q    <= 1'b0;
		end else if (cmd.finish) begin
			out_sample_q <= lat_ok_q ? lat_rd[SAMPLE_W-1:0] : '0;
			out_sat_q    <= lat_ok_q && lat_rd[SAMPLE_W];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_sample    = out_sample_q;
	assign out_saturated = out_sat_q;
endmodule

// ===== hdl/pfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Convolver controller
// Sequences tap loads, passthrough and the per-tap multiply-accumulate loop.
// ----------------------------------------------------------------------------
module pfc_ctrl
	import pfc_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sts_t                          sts,
	input  logic [$clog2(MAX_TAPS+1)-1:0] n_taps,
	output cmd_t                          cmd
);
	localparam int CW = $clog2(MAX_TAPS + 1);

	typedef enum logic [2:0] {
		IDLE,
		DECODE,
		PASS,
		MAC,
		DRAIN
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  k_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE: begin
				cmd.capture = in_valid;
			end
			DECODE: begin
				cmd.load_tap   = !sts.mode_sample;
				cmd.hist_write = sts.mode_sample && !sts.len_zero;
			end
			PASS: begin
				cmd.pass_out = sts.out_free;
			end
			MAC: begin
				cmd.mac_issue = 1'b1;
			end
			DRAIN: begin
				cmd.finish = !sts.pipe_busy && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= DECODE;
					end
				end
				DECODE: begin
					if (!sts.mode_sample) begin
						state_q <= IDLE;
					end else if (sts.len_zero) begin
						state_q <= PASS;
					end else begin
						k_q     <= n_taps;
						state_q <= MAC;
					end
				end
				PASS: begin
					if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				MAC: begin
					k_q <= k_q - 1'b1;
					if (k_q == CW'(1)) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (!sts.pipe_busy && sts.out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hdl/pfc_checker.sv =====
// ----------------------------------------------------------------------------
// Convolver port checker
// Checks the result handshake and the item sequencing seen at the ports.
// ----------------------------------------------------------------------------
module pfc_checker
	import pfc_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_mode,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] out_sample,
	input logic                       out_saturated
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result valid dropped before its transfer.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(out_saturated))
		else $error("Result payload changed while stalled.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Item channel ready right after a transfer.");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_mode == MODE_LOAD)
		|=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("A tap load produced a result.");
endmodule

bind partitioned_fir_convolver pfc_checker u_pfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.in_mode       (item.mode),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_sample    (result.out_sample),
	.out_saturated (result.saturated)
);
